// File: rtl/point_in_mesh_ray_parity_unit_macros.svh
// Assertion helpers shared by the point-in-mesh blocks.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef POINT_IN_MESH_RAY_PARITY_UNIT_MACROS_SVH
`define POINT_IN_MESH_RAY_PARITY_UNIT_MACROS_SVH

// same-cycle implication
`define PMRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pmrp check failed");

// next-cycle implication
`define PMRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pmrp check failed");

`endif

// File: rtl/pmrp_pkg.sv
package pmrp_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_FACES_DEF    = 1024;

    // word field widths
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 10;
    localparam int COORD_W  = 32;
    localparam int CORNER_W = 10;
    localparam int CFG_W    = 11;
    localparam int ODD_W    = 2;

    // reciprocal shift for the corner wrap
    localparam int RECIP_SH = 27;

    localparam int QUEUE_DEPTH = 2;

    // datapath widths
    localparam int E_W   = 33;   // edge and offset components
    localparam int LO_W  = 33;   // low split of a normal component
    localparam int B_W   = 34;   // second multiplier operand
    localparam int N_W   = 67;   // cross product components
    localparam int P_W   = 67;   // product register
    localparam int ACC_W = 102;  // accumulator, holds the triple product
    localparam int SUM_W = 69;   // three-term sum in the hit test

    localparam int STEPS  = 24;
    localparam int STEP_W = 5;

    typedef enum logic [1:0] {
        CMD_VERTEX   = 2'd0,
        CMD_TRIANGLE = 2'd1,
        CMD_QUERY    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OPA_E1,
        OPA_E2,
        OPA_S
    } t_asel;

    typedef enum logic [2:0] {
        OPB_E1,
        OPB_E2,
        OPB_S,
        OPB_NLO,
        OPB_NHI
    } t_bsel;

    typedef enum logic [1:0] {
        DST_N,
        DST_U,
        DST_W,
        DST_NT
    } t_dst;

    typedef struct packed {
        t_asel       a_sel;
        logic [1:0]  a_idx;
        t_bsel       b_sel;
        logic [1:0]  b_idx;
        logic        neg;
        logic        shift;
        logic        first;
        logic        last;
        t_dst        dst;
        logic [1:0]  dst_idx;
    } t_uop;

    // Micro-op sequence for one triangle:
    //   0..5   n  = e1 x e2
    //   6..11  u  = e2 x s
    //   12..17 w  = s  x e1
    //   18..23 nt = s . n, each n component split in a low and a high half
    function automatic t_uop uop_at(input logic [STEP_W-1:0] step);
        t_uop           u;
        logic [STEP_W-1:0] k;
        logic [1:0]     c;
        logic [1:0]     c1;
        logic [1:0]     c2;
        u = '0;
        if (step < STEP_W'(18)) begin
            if (step < STEP_W'(6)) begin
                u.a_sel = OPA_E1;
                u.b_sel = OPB_E2;
                u.dst   = DST_N;
                k       = step;
            end else if (step < STEP_W'(12)) begin
                u.a_sel = OPA_E2;
                u.b_sel = OPB_S;
                u.dst   = DST_U;
                k       = step - STEP_W'(6);
            end else begin
                u.a_sel = OPA_S;
                u.b_sel = OPB_E1;
                u.dst   = DST_W;
                k       = step - STEP_W'(12);
            end
            c  = k[2:1];
            c1 = (c == 2'd2) ? 2'd0 : c + 2'd1;
            c2 = (c == 2'd0) ? 2'd2 : c - 2'd1;
            u.a_idx   = k[0] ? c2 : c1;
            u.b_idx   = k[0] ? c1 : c2;
            u.neg     = k[0];
            u.first   = !k[0];
            u.last    = k[0];
            u.dst_idx = c;
        end else begin
            k         = step - STEP_W'(18);
            c         = k[2:1];
            u.a_sel   = OPA_S;
            u.a_idx   = c;
            u.b_sel   = k[0] ? OPB_NHI : OPB_NLO;
            u.b_idx   = c;
            u.shift   = k[0];
            u.first   = (k == STEP_W'(0));
            u.last    = (k == STEP_W'(5));
            u.dst     = DST_NT;
            u.dst_idx = 2'd0;
        end
        return u;
    endfunction

    function automatic logic signed [E_W-1:0] pick_e(
        input logic signed [E_W-1:0] v0,
        input logic signed [E_W-1:0] v1,
        input logic signed [E_W-1:0] v2,
        input logic [1:0]            idx
    );
        case (idx)
            2'd0:    return v0;
            2'd1:    return v1;
            default: return v2;
        endcase
    endfunction

    function automatic logic signed [N_W-1:0] pick_n(
        input logic signed [N_W-1:0] v0,
        input logic signed [N_W-1:0] v1,
        input logic signed [N_W-1:0] v2,
        input logic [1:0]            idx
    );
        case (idx)
            2'd0:    return v0;
            2'd1:    return v1;
            default: return v2;
        endcase
    endfunction

endpackage

// File: rtl/pmrp_if.sv
interface pmrp_in_if import pmrp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
    logic [CORNER_W-1:0]        corner_a;
    logic [CORNER_W-1:0]        corner_b;
    logic [CORNER_W-1:0]        corner_c;

    modport source (
        output valid, cmd, slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c,
        output ready
    );
endinterface

interface pmrp_out_if import pmrp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               inside_res;
    logic [ODD_W-1:0]   odd_axes;

    modport source (output valid, inside_res, odd_axes, input ready);
    modport sink (input valid, inside_res, odd_axes, output ready);
endinterface

// File: rtl/point_in_mesh_ray_parity_unit.sv
// Load words (vertex, triangle) take one cycle in the execution side after the queue.
// A query runs every triangle through the single shared 33x34 multiplier, which
// computes 24 products per triangle, plus the vertex fetch and the hit test.
// One query is processed at a time; loads and queries complete in arrival order.
// Reset is synchronous, active low: clears control state and face_count to zero.
// Vertex and triangle tables are undefined until written; there is no clearing pass.
module point_in_mesh_ray_parity_unit import pmrp_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_FACES    = MAX_FACES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    pmrp_in_if.sink             i_in,
    pmrp_out_if.source          o_out
);

    localparam int VIW = $clog2(MAX_VERTICES);
    localparam int QW  = CMD_W + SLOT_W + 3 * COORD_W + 3 * VIW;

    logic [CFG_W-1:0]   r_face_count;
    logic [CFG_W-1:0]   face_lim;
    logic               f_valid;
    logic               f_ready;
    logic [QW-1:0]      f_data;
    logic               b_valid;
    logic               b_ready;
    logic [QW-1:0]      b_data;

    // face count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_count <= '0;
        end else if (i_cfg_we) begin
            r_face_count <= i_cfg_wdata;
        end
    end

    // clamp to the triangle table depth
    assign face_lim = (32'(r_face_count) > MAX_FACES) ? CFG_W'(MAX_FACES) : r_face_count;

    pmrp_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_FACES    (MAX_FACES),
        .QW           (QW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (f_valid),
        .i_q_ready (f_ready),
        .o_q_data  (f_data)
    );

    pmrp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_data  (f_data),
        .o_rd_valid (b_valid),
        .i_rd_ready (b_ready),
        .o_rd_data  (b_data)
    );

    pmrp_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_FACES    (MAX_FACES),
        .QW           (QW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_face_lim (face_lim),
        .i_q_valid  (b_valid),
        .o_q_ready  (b_ready),
        .i_q_data   (b_data),
        .o_out      (o_out)
    );

endmodule

// File: rtl/pmrp_front.sv
module pmrp_front import pmrp_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_FACES    = MAX_FACES_DEF,
    parameter int QW           = CMD_W + SLOT_W + 3 * COORD_W + 3 * 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pmrp_in_if.sink         i_in,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output logic [QW-1:0]   o_q_data
);

    localparam int VIW     = $clog2(MAX_VERTICES);
    localparam int RECIP_W = RECIP_SH + 1;
    localparam int MP_W    = RECIP_W + CORNER_W;
    localparam int RM_W    = CORNER_W + 17;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SH) + MAX_VERTICES - 1) / MAX_VERTICES);
    localparam logic [RM_W-1:0] MV_C = RM_W'(MAX_VERTICES);

    logic                       r_v;
    t_cmd                       r_cmd;
    logic [SLOT_W-1:0]          r_slot;
    logic signed [COORD_W-1:0]  r_x;
    logic signed [COORD_W-1:0]  r_y;
    logic signed [COORD_W-1:0]  r_z;
    logic [CORNER_W-1:0]        r_c [3];
    logic [CORNER_W-1:0]        r_q [3];

    logic [CORNER_W-1:0]        in_c [3];
    logic [MP_W-1:0]            qprod [3];
    logic [RM_W-1:0]            rem [3];
    logic [VIW-1:0]             wrap [3];
    logic                       keep;
    logic                       wrap_ok;

    assign in_c[0] = i_in.corner_a;
    assign in_c[1] = i_in.corner_b;
    assign in_c[2] = i_in.corner_c;

    // estimate corner / vertex count by reciprocal, then take the remainder
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qprod[i] = MP_W'(in_c[i]) * MP_W'(RECIP);
            rem[i]   = RM_W'(r_c[i]) - RM_W'(r_q[i]) * MV_C;
            wrap[i]  = VIW'(rem[i]);
        end
    end

    // classify: drop out-of-range loads and the unused command
    always_comb begin
        case (r_cmd)
            CMD_VERTEX:   keep = (32'(r_slot) < MAX_VERTICES);
            CMD_TRIANGLE: keep = (32'(r_slot) < MAX_FACES);
            CMD_QUERY:    keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    assign i_in.ready = !r_v || !keep || i_q_ready;
    assign o_q_valid  = r_v && keep;
    assign o_q_data   = {r_cmd, r_slot, r_x, r_y, r_z, wrap[0], wrap[1], wrap[2]};

    // hold the accepted word until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in.ready) begin
            r_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd  <= t_cmd'(i_in.cmd);
            r_slot <= i_in.slot;
            r_x    <= i_in.coord_x;
            r_y    <= i_in.coord_y;
            r_z    <= i_in.coord_z;
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= in_c[i];
                r_q[i] <= qprod[i][RECIP_SH +: CORNER_W];
            end
        end
    end

    assign wrap_ok = (32'(wrap[0]) < MAX_VERTICES) && (32'(wrap[1]) < MAX_VERTICES)
                     && (32'(wrap[2]) < MAX_VERTICES);

`include "point_in_mesh_ray_parity_unit_macros.svh"

    `PMRP_ASSERT_IMP(wrap_in_range, o_q_valid && r_cmd == CMD_TRIANGLE, wrap_ok)

endmodule

// File: rtl/pmrp_queue.sv
module pmrp_queue import pmrp_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_valid,
    output logic                o_wr_ready,
    input  logic [WIDTH-1:0]    i_wr_data,
    output logic                o_rd_valid,
    input  logic                i_rd_ready,
    output logic [WIDTH-1:0]    o_rd_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [QUEUE_DEPTH];
    logic [PW-1:0]      r_wp;
    logic [PW-1:0]      r_rp;
    logic [CW-1:0]      r_count;
    logic               wr;
    logic               rd;

    assign o_wr_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + CW'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

`include "point_in_mesh_ray_parity_unit_macros.svh"

    `PMRP_ASSERT_IMP(count_bound, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `PMRP_ASSERT_NEXT(count_up, wr && !rd, r_count == $past(r_count) + CW'(1))

endmodule

// File: rtl/pmrp_back.sv
module pmrp_back import pmrp_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_FACES    = MAX_FACES_DEF,
    parameter int QW           = CMD_W + SLOT_W + 3 * COORD_W + 3 * 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CFG_W-1:0]    i_face_lim,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  logic [QW-1:0]       i_q_data,
    pmrp_out_if.source          o_out
);

    localparam int VIW = $clog2(MAX_VERTICES);
    localparam int FAW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRI,
        S_VA,
        S_VB,
        S_VC,
        S_VW,
        S_MUL,
        S_CHK,
        S_DONE
    } t_state;

    // control
    t_state             r_state;
    logic [CFG_W-1:0]   r_lim;
    logic [CFG_W-1:0]   r_face;
    logic [STEP_W-1:0]  r_step;
    logic               r_pv;
    logic [2:0]         r_par;
    logic               r_out_v;
    logic               r_out_inside;
    logic [ODD_W-1:0]   r_out_odd;

    // tables
    logic [3*COORD_W-1:0]   r_vmem [MAX_VERTICES];
    logic [3*VIW-1:0]       r_tmem [MAX_FACES];
    logic [3*COORD_W-1:0]   r_vq;
    logic [3*VIW-1:0]       r_tq;

    // datapath
    logic signed [COORD_W-1:0]  r_p [3];
    logic signed [COORD_W-1:0]  r_v1 [3];
    logic signed [E_W-1:0]      r_e1 [3];
    logic signed [E_W-1:0]      r_e2 [3];
    logic signed [E_W-1:0]      r_s [3];
    logic signed [N_W-1:0]      r_n [3];
    logic signed [N_W-1:0]      r_u [3];
    logic signed [N_W-1:0]      r_w [3];
    logic signed [ACC_W-1:0]    r_nt;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [P_W-1:0]      r_prod;
    t_uop                       r_pctl;

    t_cmd                       q_cmd;
    logic [SLOT_W-1:0]          q_slot;
    logic signed [COORD_W-1:0]  q_c [3];
    logic                       pop;
    logic [VIW-1:0]             vra;
    logic signed [COORD_W-1:0]  vq_c [3];
    t_uop                       cur;
    logic                       issue;
    logic signed [E_W-1:0]      a_op;
    logic signed [B_W-1:0]      b_op;
    logic signed [N_W-1:0]      n_sel;
    logic signed [P_W-1:0]      prod_c;
    logic signed [ACC_W-1:0]    addend;
    logic signed [ACC_W-1:0]    base;
    logic signed [ACC_W-1:0]    n_acc;
    logic [2:0]                 hit;
    logic                       nt_pos;
    logic                       nt_neg;
    logic signed [SUM_W-1:0]    tsum [3];

    // unpack the queue word
    assign q_cmd  = t_cmd'(i_q_data[QW-1 -: CMD_W]);
    assign q_slot = i_q_data[QW-CMD_W-1 -: SLOT_W];
    assign q_c[0] = i_q_data[3*VIW+3*COORD_W-1 -: COORD_W];
    assign q_c[1] = i_q_data[3*VIW+2*COORD_W-1 -: COORD_W];
    assign q_c[2] = i_q_data[3*VIW+COORD_W-1 -: COORD_W];

    assign o_q_ready = (r_state == S_IDLE);
    assign pop       = (r_state == S_IDLE) && i_q_valid;

    assign vq_c[0] = r_vq[3*COORD_W-1 -: COORD_W];
    assign vq_c[1] = r_vq[2*COORD_W-1 -: COORD_W];
    assign vq_c[2] = r_vq[COORD_W-1:0];

    // pick the corner being fetched
    always_comb begin
        case (r_state)
            S_VA:    vra = r_tq[3*VIW-1 -: VIW];
            S_VB:    vra = r_tq[2*VIW-1 -: VIW];
            default: vra = r_tq[VIW-1:0];
        endcase
    end

    // table write on load, registered read
    always_ff @(posedge i_clk) begin
        if (pop && q_cmd == CMD_VERTEX) begin
            r_vmem[VIW'(q_slot)] <= {q_c[0], q_c[1], q_c[2]};
        end
        r_vq <= r_vmem[vra];
    end

    always_ff @(posedge i_clk) begin
        if (pop && q_cmd == CMD_TRIANGLE) begin
            r_tmem[FAW'(q_slot)] <= i_q_data[3*VIW-1:0];
        end
        r_tq <= r_tmem[FAW'(r_face)];
    end

    // operand select for the shared multiplier
    assign issue = (r_state == S_MUL) && (r_step != STEP_W'(STEPS));

    always_comb begin
        cur   = uop_at(r_step);
        n_sel = pick_n(r_n[0], r_n[1], r_n[2], cur.b_idx);
        case (cur.a_sel)
            OPA_E1:  a_op = pick_e(r_e1[0], r_e1[1], r_e1[2], cur.a_idx);
            OPA_E2:  a_op = pick_e(r_e2[0], r_e2[1], r_e2[2], cur.a_idx);
            default: a_op = pick_e(r_s[0], r_s[1], r_s[2], cur.a_idx);
        endcase
        case (cur.b_sel)
            OPB_E1:  b_op = B_W'(pick_e(r_e1[0], r_e1[1], r_e1[2], cur.b_idx));
            OPB_E2:  b_op = B_W'(pick_e(r_e2[0], r_e2[1], r_e2[2], cur.b_idx));
            OPB_S:   b_op = B_W'(pick_e(r_s[0], r_s[1], r_s[2], cur.b_idx));
            OPB_NLO: b_op = {1'b0, n_sel[LO_W-1:0]};
            default: b_op = n_sel[N_W-1:LO_W];
        endcase
        prod_c = a_op * b_op;
    end

    // accumulate one product behind the multiplier
    always_comb begin
        addend = r_pctl.shift ? (ACC_W'(r_prod) <<< LO_W) : ACC_W'(r_prod);
        base   = r_pctl.first ? '0 : r_acc;
        n_acc  = r_pctl.neg ? base - addend : base + addend;
    end

    // hit test per axis; det is minus the normal component
    assign nt_pos = !r_nt[ACC_W-1] && (r_nt != '0);
    assign nt_neg = r_nt[ACC_W-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tsum[k] = SUM_W'(r_u[k]) + SUM_W'(r_w[k]) + SUM_W'(r_n[k]);
            if (r_n[k] == '0) begin
                hit[k] = 1'b0;
            end else if (r_n[k][N_W-1]) begin
                hit[k] = !r_u[k][N_W-1] && !r_w[k][N_W-1]
                         && (tsum[k][SUM_W-1] || tsum[k] == '0) && nt_pos;
            end else begin
                hit[k] = (r_u[k][N_W-1] || r_u[k] == '0)
                         && (r_w[k][N_W-1] || r_w[k] == '0)
                         && !tsum[k][SUM_W-1] && nt_neg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (pop && q_cmd == CMD_QUERY) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= q_c[k];
            end
        end
        if (r_state == S_VB) begin
            for (int k = 0; k < 3; k++) begin
                r_v1[k] <= vq_c[k];
                r_s[k]  <= E_W'(r_p[k]) - E_W'(vq_c[k]);
            end
        end
        if (r_state == S_VC) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= E_W'(vq_c[k]) - E_W'(r_v1[k]);
            end
        end
        if (r_state == S_VW) begin
            for (int k = 0; k < 3; k++) begin
                r_e2[k] <= E_W'(vq_c[k]) - E_W'(r_v1[k]);
            end
        end
        if (issue) begin
            r_prod <= prod_c;
            r_pctl <= cur;
        end
        if (r_pv) begin
            r_acc <= n_acc;
            if (r_pctl.last) begin
                case (r_pctl.dst)
                    DST_N:   r_n[r_pctl.dst_idx] <= N_W'(n_acc);
                    DST_U:   r_u[r_pctl.dst_idx] <= N_W'(n_acc);
                    DST_W:   r_w[r_pctl.dst_idx] <= N_W'(n_acc);
                    default: r_nt <= n_acc;
                endcase
            end
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_lim        <= '0;
            r_face       <= '0;
            r_step       <= '0;
            r_pv         <= 1'b0;
            r_par        <= '0;
            r_out_v      <= 1'b0;
            r_out_inside <= 1'b0;
            r_out_odd    <= '0;
        end else begin
            r_pv <= issue;
            // drop the taken result word; the done state reloads it itself
            if (o_out.ready && r_state != S_DONE) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop && q_cmd == CMD_QUERY) begin
                        r_lim   <= i_face_lim;
                        r_face  <= '0;
                        r_par   <= '0;
                        r_state <= (i_face_lim == '0) ? S_DONE : S_TRI;
                    end
                end
                S_TRI: r_state <= S_VA;
                S_VA:  r_state <= S_VB;
                S_VB:  r_state <= S_VC;
                S_VC:  r_state <= S_VW;
                S_VW: begin
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (issue) begin
                        r_step <= r_step + STEP_W'(1);
                    end else if (!r_pv) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_par  <= r_par ^ hit;
                    r_face <= r_face + CFG_W'(1);
                    r_state <= (r_face + CFG_W'(1) == r_lim) ? S_DONE : S_TRI;
                end
                S_DONE: begin
                    if (!r_out_v || o_out.ready) begin
                        r_out_v      <= 1'b1;
                        r_out_odd    <= {1'b0, r_par[0]} + {1'b0, r_par[1]}
                                        + {1'b0, r_par[2]};
                        r_out_inside <= (r_par[0] && r_par[1]) || (r_par[0] && r_par[2])
                                        || (r_par[1] && r_par[2]);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.inside_res = r_out_inside;
    assign o_out.odd_axes   = r_out_odd;

`include "point_in_mesh_ray_parity_unit_macros.svh"

    `PMRP_ASSERT_IMP(step_bound, 1'b1, r_step <= STEP_W'(STEPS))
    `PMRP_ASSERT_IMP(acc_only_in_mul, r_pv, r_state == S_MUL)
    `PMRP_ASSERT_NEXT(drain_to_check, r_state == S_MUL && !issue && !r_pv, r_state == S_CHK)

endmodule
